// ----- hdl/segment_box_overlap_test_top_macros.svh -----
// ----------------------------------------------------------------------------
// segment_box_overlap_test_top_macros.svh
// Assertion macros shared by the segment/box overlap test RTL.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_OVERLAP_TEST_TOP_MACROS_SVH
`define SEGMENT_BOX_OVERLAP_TEST_TOP_MACROS_SVH

// Clocked check, off while reset is asserted (active-low reset).
`define SBOT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SBOT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/sbot_pkg.sv -----
// ----------------------------------------------------------------------------
// sbot_pkg
// Shared types for the segment/box overlap test.
// ----------------------------------------------------------------------------
package sbot_pkg;

    // Partial verdicts of the geometry pass, combined into hit by the top level.
    typedef struct packed {
        logic reject;        // bounding boxes are disjoint
        logic end_inside;    // an endpoint lies in the closed box
        logic vertical;      // segment has zero x extent
        logic cross_left;    // segment meets the left edge
        logic cross_right;   // segment meets the right edge
        logic cross_bottom;  // segment meets the bottom edge
        logic cross_top;     // segment meets the top edge
    } t_hit_terms;

endpackage

// ----- hdl/segment_box_overlap_test_top.sv -----
// ----------------------------------------------------------------------------
// segment_box_overlap_test_top
// Streaming test of a line segment against a closed axis-aligned box.
// ----------------------------------------------------------------------------
// Takes one query beat per clock unless stalled (box corner, width, height,
// two segment endpoints, Q.4 fixed point) and returns one hit beat per query,
// in order. Sustained rate is one beat per cycle while i_out_ready is high;
// a query passes an input register, then a single exact pass of four signed
// cross products with their compares, then the result register.
// That pass (the COORD_BITS+2 square multipliers) sets the clock limit. Both
// sides use valid/ready and stall independently; no configuration, no state.
// ----------------------------------------------------------------------------
`include "segment_box_overlap_test_top_macros.svh"

module segment_box_overlap_test_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_box_left,
    input  logic signed [COORD_BITS-1:0] i_box_bottom,
    input  logic        [COORD_BITS-2:0] i_box_width,
    input  logic        [COORD_BITS-2:0] i_box_height,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_hit
);

    logic                         r_in_vld;
    logic signed [COORD_BITS-1:0] r_box_left, r_box_bottom;
    logic        [COORD_BITS-2:0] r_box_width, r_box_height;
    logic signed [COORD_BITS-1:0] r_seg_start_x, r_seg_start_y;
    logic signed [COORD_BITS-1:0] r_seg_end_x, r_seg_end_y;
    logic                         r_out_vld;
    logic                         r_hit;
    logic                         n_hit;
    logic                         advance;
    logic                         in_fire;
    sbot_pkg::t_hit_terms         terms;

    // Move the held query into the result register when that slot frees up.
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    sbot_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_box_left    (r_box_left),
        .i_box_bottom  (r_box_bottom),
        .i_box_width   (r_box_width),
        .i_box_height  (r_box_height),
        .i_seg_start_x (r_seg_start_x),
        .i_seg_start_y (r_seg_start_y),
        .i_seg_end_x   (r_seg_end_x),
        .i_seg_end_y   (r_seg_end_y),
        .o_terms       (terms)
    );

    assign n_hit = !terms.reject &&
                   (terms.end_inside || terms.vertical ||
                    terms.cross_left || terms.cross_right ||
                    terms.cross_bottom || terms.cross_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_box_left    <= i_box_left;
            r_box_bottom  <= i_box_bottom;
            r_box_width   <= i_box_width;
            r_box_height  <= i_box_height;
            r_seg_start_x <= i_seg_start_x;
            r_seg_start_y <= i_seg_start_y;
            r_seg_end_x   <= i_seg_end_x;
            r_seg_end_y   <= i_seg_end_y;
        end
        if (advance) begin
            r_hit <= n_hit;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_hit       = r_hit;

    `SBOT_ASSERT(a_reject_gives_miss, i_clk, i_rst_n, advance && terms.reject |=> !o_hit, "disjoint boxes produced a hit")
    `SBOT_ASSERT(a_inside_gives_hit, i_clk, i_rst_n, advance && !terms.reject && terms.end_inside |=> o_hit, "endpoint inside box gave no hit")
    `SBOT_ASSERT(a_held_query_stays, i_clk, i_rst_n, r_in_vld && !advance |=> r_in_vld, "held query beat dropped without moving")
    `SBOT_ASSERT(a_advance_fills_out, i_clk, i_rst_n, advance |=> o_out_valid, "query moved but no result beat appeared")
    `SBOT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid && !r_in_vld, "reset left a beat pending")

endmodule

// ----- hdl/sbot_geom.sv -----
// ----------------------------------------------------------------------------
// sbot_geom
// Exact segment versus closed box geometry, one combinational pass.
// ----------------------------------------------------------------------------
module sbot_geom #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] i_box_left,
    input  logic signed [COORD_BITS-1:0] i_box_bottom,
    input  logic        [COORD_BITS-2:0] i_box_width,
    input  logic        [COORD_BITS-2:0] i_box_height,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    output sbot_pkg::t_hit_terms         o_terms
);

    localparam int EW = COORD_BITS + 1;   // edges and points
    localparam int DW = COORD_BITS + 2;   // differences
    localparam int PW = 2 * DW;           // products

    logic                 swap;
    logic signed [EW-1:0] rx1, rx2, ry1, ry2;
    logic signed [EW-1:0] ax, ay, bx, by, ymin, ymax;
    logic signed [DW-1:0] dx, dy, ul, ur, vb, vt;
    logic signed [PW-1:0] pl, pr, qb, qt;
    logic                 in_a, in_b, dy_nz, dy_neg;

    // Order endpoints so that a is the leftmost one.
    assign swap = i_seg_start_x > i_seg_end_x;

    assign rx1 = {i_box_left[COORD_BITS-1], i_box_left};
    assign ry1 = {i_box_bottom[COORD_BITS-1], i_box_bottom};
    assign rx2 = rx1 + $signed({2'b00, i_box_width});
    assign ry2 = ry1 + $signed({2'b00, i_box_height});

    assign ax = swap ? {i_seg_end_x[COORD_BITS-1], i_seg_end_x}
                     : {i_seg_start_x[COORD_BITS-1], i_seg_start_x};
    assign ay = swap ? {i_seg_end_y[COORD_BITS-1], i_seg_end_y}
                     : {i_seg_start_y[COORD_BITS-1], i_seg_start_y};
    assign bx = swap ? {i_seg_start_x[COORD_BITS-1], i_seg_start_x}
                     : {i_seg_end_x[COORD_BITS-1], i_seg_end_x};
    assign by = swap ? {i_seg_start_y[COORD_BITS-1], i_seg_start_y}
                     : {i_seg_end_y[COORD_BITS-1], i_seg_end_y};

    assign ymin = (ay < by) ? ay : by;
    assign ymax = (ay < by) ? by : ay;

    assign dx = {bx[EW-1], bx} - {ax[EW-1], ax};
    assign dy = {by[EW-1], by} - {ay[EW-1], ay};
    assign ul = {rx1[EW-1], rx1} - {ax[EW-1], ax};
    assign ur = {rx2[EW-1], rx2} - {ax[EW-1], ax};
    assign vb = {ry1[EW-1], ry1} - {ay[EW-1], ay};
    assign vt = {ry2[EW-1], ry2} - {ay[EW-1], ay};

    // Four cross products cover all edge tests: side edges compare p against q,
    // bottom/top edges compare q against p.
    assign pl = dy * ul;
    assign pr = dy * ur;
    assign qb = dx * vb;
    assign qt = dx * vt;

    assign dy_nz  = (dy != '0);
    assign dy_neg = dy[DW-1];

    assign in_a = (ax >= rx1) && (ax <= rx2) && (ay >= ry1) && (ay <= ry2);
    assign in_b = (bx >= rx1) && (bx <= rx2) && (by >= ry1) && (by <= ry2);

    always_comb begin
        o_terms.reject      = (bx < rx1) || (ax > rx2) || (ymax < ry1) || (ymin > ry2);
        o_terms.end_inside  = in_a || in_b;
        o_terms.vertical    = (ax == bx);
        o_terms.cross_left  = (rx1 >= ax) && (rx1 <= bx) && (pl >= qb) && (pl <= qt);
        o_terms.cross_right = (rx2 >= ax) && (rx2 <= bx) && (pr >= qb) && (pr <= qt);
        // Flip the bracket when the segment runs downward.
        o_terms.cross_bottom = dy_nz && (ry1 >= ymin) && (ry1 <= ymax) &&
            (dy_neg ? ((qb <= pl) && (qb >= pr)) : ((qb >= pl) && (qb <= pr)));
        o_terms.cross_top    = dy_nz && (ry2 >= ymin) && (ry2 <= ymax) &&
            (dy_neg ? ((qt <= pl) && (qt >= pr)) : ((qt >= pl) && (qt <= pr)));
    end

endmodule
